// ===== design/u16u8_pkg.sv =====
// Package with shared types and constants of the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

   // Default depth of the code point queue between front and back.
   localparam int unsigned QueueDepthDefault = 4;

   // Byte order marks, read most significant byte first.
   localparam logic [15:0] BomBigEndian    = 16'hFEFF;
   localparam logic [15:0] BomLittleEndian = 16'hFFFE;

   // Top six bits of high (D800..DBFF) and low (DC00..DFFF) surrogates.
   localparam logic [5:0] HighSurrogateTag = 6'b110110;
   localparam logic [5:0] LowSurrogateTag  = 6'b110111;

   // Base of the supplementary planes.
   localparam logic [20:0] SupplementaryBase = 21'h10000;

   // One queue entry: the code points caused by one input byte.
   typedef struct packed {
      logic [20:0] cp0;
      logic [20:0] cp1;
      logic        cp0_valid;
      logic        cp1_valid;
      logic        string_end;
   } unit_entry_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic           valid;
      unit_entry_type entry;
   } queue_head_type;

endpackage

`default_nettype wire

// ===== design/u16u8_front.sv =====
// Front end: pairs bytes into code units, detects the byte order mark and joins surrogates.
`default_nettype none

module u16u8_front
   import u16u8_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic           csr_wr_data,
   input  wire logic           accept,
   input  wire logic [7:0]     in_byte,
   input  wire logic           final_byte,
   output logic                entry_push,
   output unit_entry_type      entry
);

   logic        default_be_ff, default_be_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        awaiting_ff, awaiting_in;
   logic        cur_be_ff, cur_be_in;
   logic [9:0]  pend_bits_ff, pend_bits_in;
   logic        pend_valid_ff, pend_valid_in;

   logic [15:0] mark;
   logic        is_bom_big;
   logic        is_bom_little;
   logic        consumed;
   logic        unit_be;
   logic [15:0] unit;
   logic        unit_valid;
   logic        unit_high;
   logic        unit_low;
   logic        flush_valid;
   logic [20:0] flush_cp;
   logic        second_valid;
   logic [20:0] second_cp;

   // Byte order mark check and code unit assembly.
   always_comb begin
      mark          = {held_byte_ff, in_byte};
      is_bom_big    = (mark == BomBigEndian);
      is_bom_little = (mark == BomLittleEndian);
      consumed      = awaiting_ff && (is_bom_big || is_bom_little);
      if (awaiting_ff) begin
         if (is_bom_big) begin
            unit_be = 1'b1;
         end else if (is_bom_little) begin
            unit_be = 1'b0;
         end else begin
            unit_be = default_be_ff;
         end
      end else begin
         unit_be = cur_be_ff;
      end
      unit       = unit_be ? {held_byte_ff, in_byte} : {in_byte, held_byte_ff};
      unit_valid = held_valid_ff && !consumed;
      unit_high  = (unit[15:10] == HighSurrogateTag);
      unit_low   = (unit[15:10] == LowSurrogateTag);
   end

   // Code points of this beat: a flushed high surrogate first, then the unit itself.
   // A waiting high surrogate leaves when a unit other than a low surrogate arrives,
   // or when the string ends without a new unit.
   always_comb begin
      flush_valid = pend_valid_ff && (unit_valid ? !unit_low : final_byte);
      flush_cp    = {5'd0, HighSurrogateTag, pend_bits_ff};
      second_valid = 1'b0;
      second_cp    = {5'd0, unit};
      if (unit_valid) begin
         if (pend_valid_ff && unit_low) begin
            second_valid = 1'b1;
            second_cp    = SupplementaryBase + {1'b0, pend_bits_ff, unit[9:0]};
         end else if (!(unit_high && !final_byte)) begin
            second_valid = 1'b1;
         end
      end
      entry.string_end = final_byte;
      if (flush_valid) begin
         entry.cp0       = flush_cp;
         entry.cp0_valid = 1'b1;
         entry.cp1       = second_cp;
         entry.cp1_valid = second_valid;
      end else begin
         entry.cp0       = second_cp;
         entry.cp0_valid = second_valid;
         entry.cp1       = second_cp;
         entry.cp1_valid = 1'b0;
      end
      entry_push = accept && (entry.cp0_valid || final_byte);
   end

   // Next state of the string tracking.
   always_comb begin
      default_be_in = csr_wr_en ? csr_wr_data : default_be_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      awaiting_in   = awaiting_ff;
      cur_be_in     = cur_be_ff;
      pend_bits_in  = pend_bits_ff;
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         if (!held_valid_ff) begin
            held_byte_in  = in_byte;
            held_valid_in = 1'b1;
         end else begin
            held_valid_in = 1'b0;
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               cur_be_in   = unit_be;
            end
         end
         if (unit_valid) begin
            pend_valid_in = unit_high && !final_byte;
            pend_bits_in  = unit[9:0];
         end
         if (final_byte) begin
            held_valid_in = 1'b0;
            awaiting_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
      end
   end

   // Control state is reset; the held byte and surrogate bits are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         default_be_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         awaiting_ff   <= 1'b1;
         cur_be_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         default_be_ff <= default_be_in;
         held_valid_ff <= held_valid_in;
         awaiting_ff   <= awaiting_in;
         cur_be_ff     <= cur_be_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      pend_bits_ff <= pend_bits_in;
   end

   // A pending high surrogate never survives the end of a string.
   a_no_pending_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && final_byte |=> !pend_valid_ff && !held_valid_ff && awaiting_ff)
      else $error("string state not cleared after final byte");

   // The second code point only appears behind a first one.
   a_cp1_needs_cp0: assert property (@(posedge clock) disable iff (reset)
      entry_push && entry.cp1_valid |-> entry.cp0_valid)
      else $error("second code point without a first");

   // An entry without code points is only pushed as the end marker of a string.
   a_bare_only_at_end: assert property (@(posedge clock) disable iff (reset)
      entry_push && !entry.cp0_valid |-> final_byte)
      else $error("empty entry pushed inside a string");

endmodule

`default_nettype wire

// ===== design/u16u8_queue.sv =====
// Short queue of code point entries between the front and back ends.
`default_nettype none

module u16u8_queue
   import u16u8_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepthDefault
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire unit_entry_type wr_entry,
   input  wire logic           rd_en,
   output queue_head_type      head,
   output logic                full
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   unit_entry_type  slots [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[wr_ptr_ff] <= wr_entry;
      end
   end

   assign head = {(count_ff != '0), slots[rd_ptr_ff]};
   assign full = (count_ff == CntW'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> head.valid)
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== design/u16u8_back.sv =====
// Back end: expands queued code points into UTF-8 bytes, one beat per cycle unless the output stalls.
`default_nettype none

module u16u8_back
   import u16u8_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_head_type head,
   output logic                rd_en,
   input  wire logic           pop,
   output logic                empty,
   output logic [7:0]          utf8_byte,
   output logic                byte_valid,
   output logic                string_end,
   output logic                last_of_run
);

   // Number of UTF-8 bytes of a code point, minus one.
   function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
      logic [1:0] len;
      if (cp[20:16] != '0) begin
         len = 2'd3;
      end else if (cp[15:11] != '0) begin
         len = 2'd2;
      end else if (cp[10:7] != '0) begin
         len = 2'd1;
      end else begin
         len = 2'd0;
      end
      return len;
   endfunction

   // One byte of the UTF-8 sequence of a code point.
   function automatic logic [7:0] utf8_byte_of(input logic [20:0] cp,
                                               input logic [1:0]  len_m1,
                                               input logic [1:0]  idx);
      logic [7:0] b;
      case ({len_m1, idx})
         4'b00_00: b = {1'b0, cp[6:0]};
         4'b01_00: b = {3'b110, cp[10:6]};
         4'b01_01: b = {2'b10, cp[5:0]};
         4'b10_00: b = {4'b1110, cp[15:12]};
         4'b10_01: b = {2'b10, cp[11:6]};
         4'b10_10: b = {2'b10, cp[5:0]};
         4'b11_00: b = {5'b11110, cp[20:18]};
         4'b11_01: b = {2'b10, cp[17:12]};
         4'b11_10: b = {2'b10, cp[11:6]};
         4'b11_11: b = {2'b10, cp[5:0]};
         default:  b = 8'h00;
      endcase
      return b;
   endfunction

   logic        code_sel_ff, code_sel_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_bv_ff, out_bv_in;
   logic        out_end_ff, out_end_in;
   logic        out_last_ff, out_last_in;

   logic [20:0] cur_cp;
   logic [1:0]  len_m1;
   logic        bare;
   logic        last_code_byte;
   logic        last_entry;
   logic        load;

   // Select the current byte of the head entry.
   always_comb begin
      cur_cp         = code_sel_ff ? head.entry.cp1 : head.entry.cp0;
      len_m1         = utf8_len_m1(cur_cp);
      bare           = !head.entry.cp0_valid;
      last_code_byte = bare || (byte_idx_ff == len_m1);
      last_entry     = last_code_byte && (bare || code_sel_ff || !head.entry.cp1_valid);
      load           = head.valid && (!out_valid_ff || pop);
      rd_en          = load && last_entry;
   end

   // Walk through code points and bytes of the head entry.
   always_comb begin
      code_sel_in = code_sel_ff;
      byte_idx_in = byte_idx_ff;
      if (load) begin
         if (last_entry) begin
            code_sel_in = 1'b0;
            byte_idx_in = 2'd0;
         end else if (last_code_byte) begin
            code_sel_in = 1'b1;
            byte_idx_in = 2'd0;
         end else begin
            byte_idx_in = byte_idx_ff + 1'b1;
         end
      end
   end

   // Output register, the result side of the block.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_bv_in    = out_bv_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = bare ? 8'h00 : utf8_byte_of(cur_cp, len_m1, byte_idx_ff);
         out_bv_in    = !bare;
         out_end_in   = last_entry && head.entry.string_end;
         out_last_in  = last_entry;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_sel_ff  <= 1'b0;
         byte_idx_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         code_sel_ff  <= code_sel_in;
         byte_idx_ff  <= byte_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_bv_ff   <= out_bv_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

   assign empty       = !out_valid_ff;
   assign utf8_byte   = out_byte_ff;
   assign byte_valid  = out_bv_ff;
   assign string_end  = out_end_ff;
   assign last_of_run = out_last_ff;

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_bv_ff |-> out_end_ff && out_last_ff && (out_byte_ff == 8'h00))
      else $error("bare end marker with wrong flags");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff |-> out_last_ff)
      else $error("string end not on last beat of run");

   a_index_reset_on_pop: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (byte_idx_ff == 2'd0) && !code_sel_ff)
      else $error("byte index not cleared after entry done");

endmodule

`default_nettype wire

// ===== design/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// Input queue side: present req_in_byte and req_final_byte with push; a beat is taken
// when push is high and full is low. Bytes of a UTF-16 string arrive one per beat,
// final_byte set on the last one. A leading FEFF or FFFE mark sets the byte order and
// is dropped; otherwise csr_wr_data, written with csr_wr_en, gives the default order.
// Result queue side: while empty is low, the oldest UTF-8 byte and its flags are on
// the rsp_ ports; pop takes it. Each input beat yields zero to six result beats, and a
// final byte that yields no data gives one bare end marker.
// On an idle block the first result beat of an input beat passes through the code point
// queue and the output register. Input beats are taken one per cycle while the code point
// queue has room; the back end sends one result beat per cycle while its output register
// is empty or being popped.
// If the receiver stalls, the output register holds and the queue fills, after which
// full stays high. Reset clears all string state, empties the queue and the output,
// and sets the default byte order to little endian.
`default_nettype none

module utf16_to_utf8_transcoder
   import u16u8_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_final_byte,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_utf8_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_string_end,
   output logic            rsp_last_of_run
);

   logic           accept;
   logic           entry_push;
   unit_entry_type entry;
   logic           rd_en;
   queue_head_type head;

   assign accept = push && !full;

   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .final_byte  (req_final_byte),
      .entry_push  (entry_push),
      .entry       (entry)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_push),
      .wr_entry (entry),
      .rd_en    (rd_en),
      .head     (head),
      .full     (full)
   );

   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .rd_en       (rd_en),
      .pop         (pop),
      .empty       (empty),
      .utf8_byte   (rsp_utf8_byte),
      .byte_valid  (rsp_byte_valid),
      .string_end  (rsp_string_end),
      .last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire
